>>> design/open_addressing_hash_table_assert.svh
// Assertion macros for the open addressing hash table.
// Included by the top level; no other dependencies.
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define OAHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash table check failed");

// Next-cycle implication, checked out of reset.
`define OAHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed");

`endif

>>> design/oaht_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the open addressing hash table. No dependencies.
package oaht_pkg;

    localparam int KEY_W           = 31;
    localparam int VALUE_W         = 32;
    localparam int KIND_W          = 2;
    localparam int SLOT_OUT_W      = 6;
    localparam int MARK_W          = 2;
    localparam int DEF_TABLE_SLOTS = 64;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    // Entry marks
    localparam logic [MARK_W-1:0] MARK_FREE    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic clear;       // clearing pass: free one mark per cycle
        logic load;        // capture request
        logic hash_step;   // one stage of key mod slots
        logic probe_init;  // reset probe sequence
        logic probe_run;   // issue/check probes
        logic commit;      // update entry at matched slot
        logic respond;     // load result registers
        logic fail;        // result is a failure
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic hash_last;
        logic kind_valid;
        logic match;
        logic exhausted;
    } ctrl_status_t;

endpackage

>>> design/oaht_ctrl.sv
// Request sequencer for the open addressing hash table.
// Depends on oaht_pkg (command/status types).
module oaht_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  oaht_pkg::ctrl_status_t stat,
    output oaht_pkg::ctrl_cmd_t   cmd,
    output logic                  busy,
    output logic                  done,
    output logic                  status
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, done_reg, status_reg;
    logic   busy_next, done_next, status_next;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last)
                begin
                    if (stat.kind_valid)
                    begin
                        cmd.probe_init = 1'b1;
                        state_next     = S_PROBE;
                    end
                    else
                    begin
                        cmd.respond = 1'b1;
                        cmd.fail    = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_PROBE:
            begin
                cmd.probe_run = 1'b1;
                if (stat.match)
                begin
                    cmd.commit  = 1'b1;
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (stat.exhausted)
                begin
                    cmd.respond = 1'b1;
                    cmd.fail    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Registered outputs
    always_comb
    begin
        busy_next   = (state_next != S_IDLE);
        done_next   = cmd.respond;
        status_next = cmd.respond ? cmd.fail : status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            busy_reg   <= 1'b1;
            done_reg   <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign status = status_reg;

endmodule

>>> design/oaht_datapath.sv
// Datapath of the open addressing hash table: entry memories, reciprocal
// home slot reduction, probe address generator and match check.
// Depends on oaht_pkg.
module oaht_datapath
#(
    parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  oaht_pkg::ctrl_cmd_t                 cmd,
    output oaht_pkg::ctrl_status_t              stat,
    input  logic                                probe_mode_we,
    input  logic                                probe_mode,
    input  logic [oaht_pkg::KIND_W-1:0]         kind,
    input  logic [oaht_pkg::KEY_W-1:0]          key,
    input  logic signed [oaht_pkg::VALUE_W-1:0] value,
    output logic [oaht_pkg::SLOT_OUT_W-1:0]     slot
);

    localparam int KEY_W  = oaht_pkg::KEY_W;
    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam logic [SLOT_W:0]    SLOTS_EXT = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [CNT_W-1:0]   SLOTS_CNT = CNT_W'(TABLE_SLOTS);
    localparam logic [CNT_W-1:0]   LAST_CNT  = CNT_W'(TABLE_SLOTS - 1);
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    // floor(2^KEY_W / slots): the quotient estimate is exact or one short
    localparam logic [KEY_W-1:0]   RECIP     =
        KEY_W'((64'(1) << KEY_W) / 64'(TABLE_SLOTS));
    localparam logic [KEY_W-1:0]   SLOTS_KEY = KEY_W'(TABLE_SLOTS);
    localparam logic [1:0]         HASH_LAST = 2'd2;

    // Entry stores
    logic [oaht_pkg::MARK_W-1:0]  mark_mem  [TABLE_SLOTS];
    logic [oaht_pkg::KEY_W-1:0]   key_mem   [TABLE_SLOTS];
    logic [oaht_pkg::VALUE_W-1:0] value_mem [TABLE_SLOTS];

    logic                         probe_mode_reg;
    logic [oaht_pkg::KIND_W-1:0]  kind_reg;
    logic [oaht_pkg::KEY_W-1:0]   key_reg;
    logic [oaht_pkg::VALUE_W-1:0] value_reg;
    logic [SLOT_W-1:0]            clr_cnt_reg;
    logic [1:0]                   hash_cnt_reg;
    logic [2*KEY_W-1:0]           prod_reg, prod_next;
    logic [SLOT_W:0]              rem_reg, rem_next;
    logic [SLOT_W-1:0]            home_reg;
    logic [SLOT_W-1:0]            off_reg, off_next;
    logic [SLOT_W-1:0]            odd_reg, odd_next;
    logic [CNT_W-1:0]             issue_cnt_reg;
    logic                         rd_vld_reg;
    logic                         rd_last_reg;
    logic [SLOT_W-1:0]            rd_slot_reg;
    logic [oaht_pkg::MARK_W-1:0]  mark_rd_reg;
    logic [oaht_pkg::KEY_W-1:0]   key_rd_reg;
    logic [oaht_pkg::SLOT_OUT_W-1:0] slot_reg;

    logic [KEY_W-1:0]             quot, quot_slots;
    logic [SLOT_W:0]              addr_sum, off_sum, odd_sum;
    logic [SLOT_W-1:0]            home_next, probe_addr, inc;
    logic                         issuing;
    logic                         hit_cond;
    logic                         mark_we;
    logic [SLOT_W-1:0]            mark_waddr;
    logic [oaht_pkg::MARK_W-1:0]  mark_wdata;
    logic [SLOT_W+oaht_pkg::SLOT_OUT_W-1:0] slot_wide;

    // Home slot in three stages: reciprocal multiply, multiply back and
    // subtract (remainder below 2*slots), final conditional subtract
    always_comb
    begin
        prod_next  = (2 * KEY_W)'(key_reg) * (2 * KEY_W)'(RECIP);
        quot       = prod_reg[2*KEY_W-1:KEY_W];
        quot_slots = quot * SLOTS_KEY;
        rem_next   = (SLOT_W + 1)'(key_reg - quot_slots);
        home_next  = (rem_reg >= SLOTS_EXT) ? SLOT_W'(rem_reg - SLOTS_EXT) : SLOT_W'(rem_reg);
    end

    // Probe address and incremental offset (j or j*j, both mod slots)
    always_comb
    begin
        addr_sum   = {1'b0, home_reg} + {1'b0, off_reg};
        probe_addr = (addr_sum >= SLOTS_EXT) ? SLOT_W'(addr_sum - SLOTS_EXT)
                                             : SLOT_W'(addr_sum);
        inc        = probe_mode_reg ? odd_reg : SLOT_W'(1);
        off_sum    = {1'b0, off_reg} + {1'b0, inc};
        off_next   = (off_sum >= SLOTS_EXT) ? SLOT_W'(off_sum - SLOTS_EXT) : SLOT_W'(off_sum);
        odd_sum    = {1'b0, odd_reg} + (SLOT_W + 1)'(2);
        odd_next   = (odd_sum >= SLOTS_EXT) ? SLOT_W'(odd_sum - SLOTS_EXT) : SLOT_W'(odd_sum);
        issuing    = cmd.probe_run && (issue_cnt_reg != SLOTS_CNT);
    end

    // Match check on the registered read data
    always_comb
    begin
        case (kind_reg)
            oaht_pkg::KIND_INSERT:
                hit_cond = (mark_rd_reg == oaht_pkg::MARK_FREE) ||
                           (mark_rd_reg == oaht_pkg::MARK_DELETED);
            oaht_pkg::KIND_DELETE, oaht_pkg::KIND_LOOKUP:
                hit_cond = (mark_rd_reg == oaht_pkg::MARK_USED) && (key_rd_reg == key_reg);
            default:
                hit_cond = 1'b0;
        endcase
    end

    always_comb
    begin
        stat.clear_last = (clr_cnt_reg == LAST_SLOT);
        stat.hash_last  = (hash_cnt_reg == HASH_LAST);
        stat.kind_valid = (kind_reg == oaht_pkg::KIND_INSERT) ||
                          (kind_reg == oaht_pkg::KIND_DELETE) ||
                          (kind_reg == oaht_pkg::KIND_LOOKUP);
        stat.match      = rd_vld_reg && hit_cond;
        stat.exhausted  = rd_vld_reg && rd_last_reg && !hit_cond;
    end

    // Mark write port: clearing pass or commit
    always_comb
    begin
        mark_we    = cmd.clear || (cmd.commit && ((kind_reg == oaht_pkg::KIND_INSERT) ||
                                                  (kind_reg == oaht_pkg::KIND_DELETE)));
        mark_waddr = cmd.clear ? clr_cnt_reg : rd_slot_reg;
        if (cmd.clear)
        begin
            mark_wdata = oaht_pkg::MARK_FREE;
        end
        else if (kind_reg == oaht_pkg::KIND_INSERT)
        begin
            mark_wdata = oaht_pkg::MARK_USED;
        end
        else
        begin
            mark_wdata = oaht_pkg::MARK_DELETED;
        end
    end

    // Memories: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (cmd.commit && (kind_reg == oaht_pkg::KIND_INSERT))
        begin
            key_mem[rd_slot_reg]   <= key_reg;
            value_mem[rd_slot_reg] <= value_reg;
        end
        mark_rd_reg <= mark_mem[probe_addr];
        key_rd_reg  <= key_mem[probe_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_mode_reg <= 1'b0;
            clr_cnt_reg    <= '0;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
            issue_cnt_reg  <= '0;
            hash_cnt_reg   <= '0;
        end
        else
        begin
            if (probe_mode_we)
            begin
                probe_mode_reg <= probe_mode;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
            if (cmd.load)
            begin
                hash_cnt_reg <= '0;
            end
            else if (cmd.hash_step && !stat.hash_last)
            begin
                hash_cnt_reg <= hash_cnt_reg + 2'd1;
            end
            if (cmd.probe_init)
            begin
                issue_cnt_reg <= '0;
                rd_vld_reg    <= 1'b0;
                rd_last_reg   <= 1'b0;
            end
            else if (cmd.probe_run)
            begin
                rd_vld_reg  <= issuing;
                rd_last_reg <= issuing && (issue_cnt_reg == LAST_CNT);
                if (issuing)
                begin
                    issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            key_reg   <= key;
            value_reg <= value;
        end
        if (cmd.hash_step)
        begin
            prod_reg <= prod_next;
            rem_reg  <= rem_next;
            home_reg <= home_next;
        end
        if (cmd.probe_init)
        begin
            off_reg <= '0;
            odd_reg <= SLOT_W'(1);
        end
        else if (issuing)
        begin
            off_reg <= off_next;
            odd_reg <= odd_next;
        end
        if (cmd.probe_run)
        begin
            rd_slot_reg <= probe_addr;
        end
        if (cmd.respond)
        begin
            slot_reg <= cmd.fail ? '0 : slot_wide[oaht_pkg::SLOT_OUT_W-1:0];
        end
    end

    assign slot_wide = {{oaht_pkg::SLOT_OUT_W{1'b0}}, rd_slot_reg};
    assign slot      = slot_reg;

endmodule

>>> design/open_addressing_hash_table.sv
// Open addressing hash table: key/value entries marked free, used or
// deleted, probed linearly or quadratically from home slot key mod slots.
//
// Requests: kind, key, value are taken when start is high and busy low.
// Results: status and slot are valid for the single cycle that done is
// high; the receiver has no way to stall them.
// Configuration: probe_mode is written when probe_mode_we is high.
// Operation: the home slot is formed by a reciprocal multiply, a multiply
// back and subtract, and a final correction, then one probe issues per cycle
// through the mark/key read port, whose read is registered. done follows the
// first matching probe, or the last probe of a full probe path. A request of
// kind 3 fails once the home slot is formed, without probing. One request is
// in flight at a time; busy drops as done rises.
// Reset: all marks are cleared by a pass over every entry, one entry
// per cycle, with busy held high; probe_mode resets to linear.
// Depends on oaht_pkg, oaht_ctrl, oaht_datapath and the assertion header.
`include "open_addressing_hash_table_assert.svh"
module open_addressing_hash_table
#(
    parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [oaht_pkg::KIND_W-1:0]         kind,
    input  logic [oaht_pkg::KEY_W-1:0]          key,
    input  logic signed [oaht_pkg::VALUE_W-1:0] value,
    output logic                                done,
    output logic                                status,
    output logic [oaht_pkg::SLOT_OUT_W-1:0]     slot,
    input  logic                                probe_mode_we,
    input  logic                                probe_mode
);

    oaht_pkg::ctrl_cmd_t    cmd;
    oaht_pkg::ctrl_status_t stat;

    // Sequencer
    oaht_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .status (status)
    );

    // Memories and arithmetic
    oaht_datapath
    #(
        .TABLE_SLOTS (TABLE_SLOTS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .probe_mode_we (probe_mode_we),
        .probe_mode    (probe_mode),
        .kind          (kind),
        .key           (key),
        .value         (value),
        .slot          (slot)
    );

    // Checks
    `OAHT_ASSERT_NOW(a_fail_slot_zero, clk, rst_n, done && status, slot == '0)
    `OAHT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `OAHT_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    `OAHT_ASSERT_NOW(a_commit_on_match, clk, rst_n, cmd.commit, stat.match && !cmd.fail)

endmodule

>>> sim/tb_open_addressing_hash_table.sv
// Self-checking testbench for open_addressing_hash_table: a scoreboard class predicts
// status and slot for every request, and plain tasks drive the command and config ports.
// Depends on oaht_pkg and the design sources only.
`timescale 1ns / 100ps

module tb_open_addressing_hash_table;
    import oaht_pkg::*;

    localparam int SLOTS     = DEF_TABLE_SLOTS;
    localparam int POOL_SIZE = 48;
    localparam int PHASES    = 6;
    localparam int PHASE_LEN = 200;
    localparam int PRINT_CAP = 50;
    // kind 3 has no package name; the block must refuse it
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      start         = 1'b0;
    logic [KIND_W-1:0]         kind          = KIND_INSERT;
    logic [KEY_W-1:0]          key           = '0;
    logic signed [VALUE_W-1:0] value         = '0;
    logic                      probe_mode_we = 1'b0;
    logic                      probe_mode    = 1'b0;
    logic                      busy;
    logic                      done;
    logic                      status;
    logic [SLOT_OUT_W-1:0]     slot;

    // Predicts the table contents and the answer to every request, in order.
    class table_scoreboard;
        typedef struct packed {
            logic                  status;
            logic [SLOT_OUT_W-1:0] slot;
        } answer_t;

        logic [MARK_W-1:0] mark [SLOTS];
        logic [KEY_W-1:0]  stored_key [SLOTS];   // values never come back out
        logic              quad_mode;
        answer_t           answers_due [$];
        int                mismatches;
        int                n_insert, n_delete, n_lookup, n_unknown, n_full, n_miss;

        function new();
            foreach (mark[i])
                mark[i] = MARK_FREE;
            quad_mode  = 1'b0;
            mismatches = 0;
            n_insert   = 0;
            n_delete   = 0;
            n_lookup   = 0;
            n_unknown  = 0;
            n_full     = 0;
            n_miss     = 0;
        endfunction

        // Slot visited by probe number j.
        function int unsigned probe_at(logic [KEY_W-1:0] k, int unsigned j);
            logic [63:0] step;
            step = quad_mode ? 64'(j) * 64'(j) : 64'(j);
            return int'((64'(k) + step) % 64'(SLOTS));
        endfunction

        // First used entry on the probe path holding k, or -1.
        function int find_entry(logic [KEY_W-1:0] k);
            int          hit;
            int unsigned s;
            hit = -1;
            for (int unsigned j = 0; j < SLOTS && hit < 0; j++)
            begin
                s = probe_at(k, j);
                if (mark[s] == MARK_USED && stored_key[s] == k)
                    hit = int'(s);
            end
            return hit;
        endfunction

        // Accepted request: update the table copy and queue the answer.
        function void note_request(logic [KIND_W-1:0] k_kind, logic [KEY_W-1:0] k);
            int          hit;
            int unsigned s;
            answer_t     ans;
            hit = -1;
            case (k_kind)
                KIND_INSERT:
                begin
                    n_insert++;
                    for (int unsigned j = 0; j < SLOTS && hit < 0; j++)
                    begin
                        s = probe_at(k, j);
                        if (mark[s] == MARK_FREE || mark[s] == MARK_DELETED)
                        begin
                            mark[s]       = MARK_USED;
                            stored_key[s] = k;
                            hit           = int'(s);
                        end
                    end
                    if (hit < 0)
                        n_full++;
                end
                KIND_DELETE:
                begin
                    n_delete++;
                    hit = find_entry(k);
                    if (hit >= 0)
                        mark[hit] = MARK_DELETED;
                    else
                        n_miss++;
                end
                KIND_LOOKUP:
                begin
                    n_lookup++;
                    hit = find_entry(k);
                    if (hit < 0)
                        n_miss++;
                end
                default:
                begin
                    n_unknown++;
                end
            endcase
            ans.status = (hit < 0);
            ans.slot   = (hit < 0) ? '0 : SLOT_OUT_W'(hit);
            answers_due.push_back(ans);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Result strobe: compare with the oldest outstanding answer.
        task check_answer(logic got_status, logic [SLOT_OUT_W-1:0] got_slot);
            answer_t want;
            if (answers_due.size() == 0)
            begin
                report_mismatch($sformatf("result with no request pending (status %0d slot %0d)",
                                          got_status, got_slot));
            end
            else
            begin
                want = answers_due.pop_front();
                if (got_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got_status, want.status));
                if (got_slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d", got_slot, want.slot));
            end
        endtask

        task wrap_up();
            if (answers_due.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", answers_due.size()));
        endtask
    endclass

    table_scoreboard  sb;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    bit               steady = 1'b0;   // no sender idling while set
    int               mode_writes = 0;
    int unsigned      ins_pct  [PHASES] = '{70, 30, 55, 75, 25, 50};
    int unsigned      del_pct  [PHASES] = '{10, 45, 20, 10, 50, 25};
    bit               mode_seq [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    open_addressing_hash_table #(
        .TABLE_SLOTS(SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .key          (key),
        .value        (value),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .probe_mode_we(probe_mode_we),
        .probe_mode   (probe_mode)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor: results first, so a request taken on the done edge queues behind it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_answer(status, slot);
            if (start && !busy)
                sb.note_request(kind, key);
        end
    end

    // Sender idle gap; start drops at the first falling edge.
    task automatic idle_for(int unsigned n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Present one request and hold it until the block takes it; start stays high.
    task automatic send_request(logic [KIND_W-1:0] req_kind, logic [KEY_W-1:0] req_key,
                                logic signed [VALUE_W-1:0] req_value);
        if (!steady && $urandom_range(0, 99) < 7)
            idle_for($urandom_range(1, 40));
        @(negedge clk);
        start <= 1'b1;
        kind  <= req_kind;
        key   <= req_key;
        value <= req_value;
        do @(posedge clk); while (busy);
    endtask

    // Stop issuing and wait until every answer is in.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.answers_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_probe_mode(logic m);
        drain();
        @(negedge clk);
        probe_mode_we <= 1'b1;
        probe_mode    <= m;
        sb.quad_mode   = m;
        mode_writes++;
        @(negedge clk);
        probe_mode_we <= 1'b0;
    endtask

    // Mostly pool keys that crowd a few home slots, some fully random.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return KEY_W'($urandom());
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic send_random(int unsigned ins, int unsigned del);
        int unsigned       r;
        logic [KIND_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 4)
            k = KIND_UNUSED;
        else if (r < 4 + ins)
            k = KIND_INSERT;
        else if (r < 4 + ins + del)
            k = KIND_DELETE;
        else
            k = KIND_LOOKUP;
        send_request(k, pick_key(), $urandom());
    endtask

    initial
    begin
        int unsigned r;
        sb = new();

        // home slots near both ends of the table, so linear probes wrap
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            r = $urandom_range(0, 7);
            key_pool[i] = {25'($urandom()), 6'((r < 4) ? r : 56 + r)};
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // clearing pass holds busy high
        do @(posedge clk); while (busy);

        // Directed, linear probing
        write_probe_mode(1'b0);
        send_request(KIND_LOOKUP, 31'd5, 32'sd0);                  // empty table: absent
        send_request(KIND_DELETE, 31'd5, -32'sd1);                 // delete absent key
        send_request(KIND_INSERT, 31'd0, 32'sh8000_0000);          // slot 0
        send_request(KIND_INSERT, {KEY_W{1'b1}}, 32'sh7fff_ffff);  // slot 63
        send_request(KIND_INSERT, 31'd64, -32'sd1);                // collides, slot 1
        send_request(KIND_INSERT, 31'd127, 32'sd0);                // wraps past 63 to slot 2
        send_request(KIND_DELETE, 31'd0, 32'sd0);
        send_request(KIND_LOOKUP, 31'd0, 32'sd0);                  // gone
        send_request(KIND_LOOKUP, 31'd64, 32'sd0);                 // past a deleted slot
        send_request(KIND_INSERT, 31'd128, 32'sd0);                // reuses deleted slot 0
        send_request(KIND_UNUSED, {KEY_W{1'b1}}, -32'sd1);         // unknown kind

        // Directed, quadratic probing
        write_probe_mode(1'b1);
        send_request(KIND_INSERT, 31'd0, 32'sd1);                  // lands on slot 4
        send_request(KIND_LOOKUP, 31'd127, 32'sd0);                // slot 2 not on its path
        send_request(KIND_LOOKUP, 31'd0, 32'sd0);
        // key 32 reaches only 12 slots, two already taken: fill, then one more is full
        for (int i = 0; i < 11; i++)
            send_request(KIND_INSERT, 31'd32, 32'($urandom()));

        // Random phases: insert-heavy to fill the table, delete-heavy to drain it
        for (int p = 0; p < PHASES; p++)
        begin
            write_probe_mode(mode_seq[p]);
            steady = (p == 2);
            for (int i = 0; i < PHASE_LEN; i++)
                send_random(ins_pct[p], del_pct[p]);
        end
        steady = 1'b0;

        drain();
        repeat (SLOTS + 40) @(posedge clk);
        sb.wrap_up();

        $display("Requests: %0d inserts (%0d table full), %0d deletes, %0d lookups",
                 sb.n_insert, sb.n_full, sb.n_delete, sb.n_lookup);
        $display("Misses on delete/lookup: %0d, unknown kinds: %0d, probe mode writes: %0d",
                 sb.n_miss, sb.n_unknown, mode_writes);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
